/* hw/rtl/pfcab_pkg.sv */
// ----------------------------------------------------------------------------
// pfcab_pkg
// Shared types, codes and helpers for the pixel format convert / blend core.
// ----------------------------------------------------------------------------
package pfcab_pkg;

  typedef enum logic {
    FMT_RGB565   = 1'b0,
    FMT_ARGB4444 = 1'b1
  } fmt_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 1'b1;

  localparam int PIX_W = 16;

  localparam logic [3:0] ALPHA_FULL = 4'hF;

  // floor(x/15) for x <= 945 via reciprocal 2185/2^15
  localparam logic [11:0] DIV15_MUL = 12'd2185;
  localparam int          DIV15_SH  = 15;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             we;
  } res_t;

  function automatic logic [5:0] div15(input logic [9:0] x);
    logic [21:0] prod;
    prod = {12'd0, x} * {10'd0, DIV15_MUL};
    return prod[DIV15_SH +: 6];
  endfunction

endpackage

/* hw/rtl/pixel_format_convert_and_alpha_blend.sv */
// A beat passes through two registers: the input register, then the result register.
// Throughput: one pixel per cycle while out_ready holds; the fully combinational blend
// datapath lies between them; both registers advance together when the output drains.
// Reset (synchronous, active low): pipeline emptied, both format registers set to
// RGB565.
// ----------------------------------------------------------------------------
// pixel_format_convert_and_alpha_blend
// Per-pixel blit core: source format conversion and alpha blend over destination.
// ----------------------------------------------------------------------------
module pixel_format_convert_and_alpha_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pfcab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfcab_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     in_source_pixel,
  input  logic [15:0]                     in_background_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_pixel_out,
  output logic                            out_write_enable
);
  import pfcab_pkg::*;

  fmt_t        src_fmt_r;
  fmt_t        tgt_fmt_r;
  logic        s1_valid_r;
  logic [15:0] s1_src_r;
  logic [15:0] s1_bg_r;
  logic        out_valid_r;
  res_t        out_res_r;
  res_t        res_nxt;
  logic        s1_ready;

  assign s1_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_RGB565;
      tgt_fmt_r <= FMT_RGB565;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_FORMAT: src_fmt_r <= fmt_t'(cfg_wdata[0]);
        CFG_TARGET_FORMAT: tgt_fmt_r <= fmt_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_src_r <= in_source_pixel;
      s1_bg_r  <= in_background_pixel;
    end
  end

  pfcab_core u_core (
    .src     (s1_src_r),
    .bg      (s1_bg_r),
    .src_fmt (src_fmt_r),
    .tgt_fmt (tgt_fmt_r),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_res_r.pix;
  assign out_write_enable = out_res_r.we;

endmodule

/* hw/rtl/pfcab_core.sv */
// ----------------------------------------------------------------------------
// pfcab_core
// Format conversion and alpha blend of one pixel, combinational.
// ----------------------------------------------------------------------------
module pfcab_core (
  input  logic [15:0]      src,
  input  logic [15:0]      bg,
  input  pfcab_pkg::fmt_t  src_fmt,
  input  pfcab_pkg::fmt_t  tgt_fmt,
  output pfcab_pkg::res_t  res
);
  import pfcab_pkg::*;

  logic [3:0] a;
  logic [3:0] ia;
  logic [4:0] fr;
  logic [5:0] fg;
  logic [4:0] fb;
  logic [9:0] sum_r;
  logic [9:0] sum_g;
  logic [9:0] sum_b;
  logic [5:0] q_r;
  logic [5:0] q_g;
  logic [5:0] q_b;
  logic [15:0] blend_pix;
  logic [15:0] cut_pix;

  assign a  = src[15:12];
  assign ia = ALPHA_FULL - a;
  assign fr = {src[11:8], 1'b0};
  assign fg = {src[7:4], 2'b00};
  assign fb = {src[3:0], 1'b0};

  assign sum_r = {5'd0, bg[15:11]} * {6'd0, ia} + {5'd0, fr} * {6'd0, a};
  assign sum_g = {4'd0, bg[10:5]}  * {6'd0, ia} + {4'd0, fg} * {6'd0, a};
  assign sum_b = {5'd0, bg[4:0]}   * {6'd0, ia} + {5'd0, fb} * {6'd0, a};

  assign q_r = div15(sum_r);
  assign q_g = div15(sum_g);
  assign q_b = div15(sum_b);

  assign blend_pix = {q_r[4:0], q_g, q_b[4:0]};
  assign cut_pix   = {ALPHA_FULL, src[15:12], src[10:7], src[4:1]};

  always_comb begin
    res.pix = src;
    res.we  = 1'b1;
    if (src_fmt == tgt_fmt) begin
      res.pix = src;
    end else if (tgt_fmt == FMT_ARGB4444) begin
      res.pix = cut_pix;
    end else begin
      res.pix = blend_pix;
      res.we  = (a != 4'd0);
    end
  end

endmodule

/* hw/rtl/pfcab_checker.sv */
// ----------------------------------------------------------------------------
// pfcab_checker
// Port-level checks for the blit core, bound to the top level.
// ----------------------------------------------------------------------------
module pfcab_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [pfcab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pfcab_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [15:0]                      out_pixel_out,
  input logic                             out_write_enable
);
  import pfcab_pkg::*;

  logic src_fmt_r;
  logic tgt_fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= 1'b0;
      tgt_fmt_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SOURCE_FORMAT) begin
        src_fmt_r <= cfg_wdata[0];
      end
      if (cfg_index == CFG_TARGET_FORMAT) begin
        tgt_fmt_r <= cfg_wdata[0];
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
    $stable(out_write_enable))
    else $error("stalled result beat changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_skip_only_blend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> src_fmt_r && !tgt_fmt_r)
    else $error("write skipped outside ARGB4444 to RGB565 blend");

endmodule

bind pixel_format_convert_and_alpha_blend pfcab_checker u_pfcab_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_wdata        (cfg_wdata),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pixel_out    (out_pixel_out),
  .out_write_enable (out_write_enable)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Blit core check: every format pair, blends and transparent skips, with
// random idling on both sides and a scoreboard fed by a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfcab_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int IDLE_PCT     = 33;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] bg;
  } blit_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           in_source_pixel;
  logic [15:0]           in_background_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           out_pixel_out;
  logic                  out_write_enable;

  blit_item_t blit_queue[$];
  res_t       expected_pixels[$];

  fmt_t src_fmt = FMT_RGB565;
  fmt_t dst_fmt = FMT_RGB565;
  bit   calm = 1'b0;
  bit   [3:0] seen_pairs = '0;

  int n_errors    = 0;
  int n_checked   = 0;
  int n_blend     = 0;
  int n_skip      = 0;
  int n_settings  = 0;
  int cycle_count = 0;
  int rx_hold_left = 0;
  bit rx_hold_done = 1'b0;

  pixel_format_convert_and_alpha_blend DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_source_pixel     (in_source_pixel),
    .in_background_pixel (in_background_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_out       (out_pixel_out),
    .out_write_enable    (out_write_enable)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic res_t convert_blend(fmt_t sf, fmt_t tf, logic [15:0] src,
                                         logic [15:0] bg);
    res_t r;
    int   a, fr, fg, fb, cr, cg, cb;
    a  = int'(src[15:12]);
    fr = int'(src[11:8]) << 1;
    fg = int'(src[7:4]) << 2;
    fb = int'(src[3:0]) << 1;
    r.we  = 1'b1;
    r.pix = src;
    if (sf != tf) begin
      if (tf == FMT_ARGB4444) begin
        r.pix = {ALPHA_FULL, src[15:12], src[10:7], src[4:1]};
      end else if (a == int'(ALPHA_FULL)) begin
        r.pix = {src[11:8], 1'b0, src[7:4], 2'b00, src[3:0], 1'b0};
      end else if (a == 0) begin
        r.pix = bg;
        r.we  = 1'b0;
      end else begin
        cr = (int'(bg[15:11]) * (int'(ALPHA_FULL) - a) + fr * a) / int'(ALPHA_FULL);
        cg = (int'(bg[10:5]) * (int'(ALPHA_FULL) - a) + fg * a) / int'(ALPHA_FULL);
        cb = (int'(bg[4:0]) * (int'(ALPHA_FULL) - a) + fb * a) / int'(ALPHA_FULL);
        r.pix = {cr[4:0], cg[5:0], cb[4:0]};
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    blit_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(convert_blend(src_fmt, dst_fmt, in_source_pixel,
                                                in_background_pixel));
        if (src_fmt == FMT_ARGB4444 && dst_fmt == FMT_RGB565) begin
          if (in_source_pixel[15:12] == 4'h0) n_skip++;
          else if (in_source_pixel[15:12] != ALPHA_FULL) n_blend++;
        end
      end
      if (!in_valid || in_ready) begin
        if (blit_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          it = blit_queue.pop_front();
          in_valid            <= 1'b1;
          in_source_pixel     <= it.src;
          in_background_pixel <= it.bg;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected beat: pixel_out=%h write_enable=%b", out_pixel_out,
                 out_write_enable);
          n_errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want.pix) begin
            $error("pixel_out: expected %h, got %h", want.pix, out_pixel_out);
            n_errors++;
          end
          if (out_write_enable !== want.we) begin
            $error("write_enable: expected %b, got %b", want.we, out_write_enable);
            n_errors++;
          end
        end
        n_checked++;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (!rx_hold_done && n_checked == HOLD_AT) begin
        rx_hold_done = 1'b1;
        rx_hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic settle();
    do @(negedge clk);
    while (blit_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_format(input logic [CFG_IDX_W-1:0] idx, input fmt_t f);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE_FORMAT) src_fmt = f;
    else dst_fmt = f;
  endtask

  task automatic queue_pixel(input logic [15:0] src, input logic [15:0] bg);
    blit_item_t it;
    it.src = src;
    it.bg  = bg;
    blit_queue.push_back(it);
  endtask

  task automatic queue_random(input fmt_t sf, input int n);
    logic [15:0] src, bg;
    repeat (n) begin
      src = 16'($urandom);
      bg  = 16'($urandom);
      if (sf == FMT_ARGB4444) begin
        case ($urandom_range(0, 3))
          0: src[15:12] = 4'h0;
          1: src[15:12] = ALPHA_FULL;
          default: ;
        endcase
      end
      case ($urandom_range(0, 7))
        0: bg = 16'h0000;
        1: bg = 16'hFFFF;
        default: ;
      endcase
      queue_pixel(src, bg);
    end
  endtask

  task automatic run_setting(input fmt_t sf, input fmt_t tf, input int n_rand,
                             input bit quiet, input bit pause_mid);
    settle();
    write_format(CFG_SOURCE_FORMAT, sf);
    write_format(CFG_TARGET_FORMAT, tf);
    n_settings++;
    calm = quiet;
    @(negedge clk);
    if (!seen_pairs[{sf, tf}]) begin
      seen_pairs[{sf, tf}] = 1'b1;
      queue_pixel(16'h0000, 16'hFFFF);
      queue_pixel(16'hFFFF, 16'h0000);
      if (sf == FMT_RGB565 && tf == FMT_ARGB4444) begin
        queue_pixel(16'hF81F, 16'h1234);
        queue_pixel(16'h07E0, 16'hABCD);
        queue_pixel(16'h0821, 16'h5555);
      end
      if (sf == FMT_ARGB4444 && tf == FMT_RGB565) begin
        // transparent, opaque and partial alpha over white, black and patterned backgrounds
        queue_pixel(16'h0ABC, 16'hFFFF);
        queue_pixel(16'h0FFF, 16'h1234);
        queue_pixel(16'hF000, 16'hFFFF);
        queue_pixel(16'hFABC, 16'h5A5A);
        queue_pixel(16'h1FFF, 16'h0000);
        queue_pixel(16'hEFFF, 16'h0000);
        queue_pixel(16'h1000, 16'hFFFF);
        queue_pixel(16'hE000, 16'hFFFF);
        queue_pixel(16'h8F0F, 16'hA5A5);
        queue_pixel(16'h70F0, 16'h07E0);
      end
      if (sf == FMT_ARGB4444 && tf == FMT_ARGB4444) begin
        queue_pixel(16'h0123, 16'hFFFF);
        queue_pixel(16'h8765, 16'h0000);
      end
    end
    queue_random(sf, n_rand / 2);
    if (pause_mid) settle();
    queue_random(sf, n_rand - n_rand / 2);
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_source_pixel     = '0;
    in_background_pixel = '0;
    out_ready           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_setting(FMT_RGB565,   FMT_RGB565,   100, 1'b0, 1'b0);
    run_setting(FMT_RGB565,   FMT_ARGB4444, 100, 1'b0, 1'b1);
    run_setting(FMT_ARGB4444, FMT_RGB565,   100, 1'b1, 1'b0);
    run_setting(FMT_ARGB4444, FMT_ARGB4444, 100, 1'b0, 1'b0);
    run_setting(FMT_ARGB4444, FMT_RGB565,   120, 1'b0, 1'b1);
    run_setting(FMT_RGB565,   FMT_ARGB4444,  90, 1'b0, 1'b0);
    run_setting(FMT_RGB565,   FMT_RGB565,    70, 1'b0, 1'b0);
    settle();

    $display("summary: %0d pixels checked over %0d format settings, all four paths",
             n_checked, n_settings);
    $display("summary: %0d partial-alpha blends, %0d transparent pixels with no write",
             n_blend, n_skip);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
